### rtl/core/smpp_pkg.sv
// ----------------------------------------------------------------------------
// smpp_pkg
// shared phase codes, field codes, status codes and limits for the parser
// ----------------------------------------------------------------------------
package smpp_pkg;

   localparam int unsigned MaxTlvCount = 10;
   localparam int unsigned LengthBits  = 16;

   // parse phases (body phases share the numbering of the field codes)
   localparam logic [4:0] PH_CMD_LEN  = 5'd0;
   localparam logic [4:0] PH_CMD_ID   = 5'd1;
   localparam logic [4:0] PH_SEQ      = 5'd3;
   localparam logic [4:0] PH_SVC_TYPE = 5'd4;
   localparam logic [4:0] PH_SRC_ADDR = 5'd7;
   localparam logic [4:0] PH_DST_ADDR = 5'd10;
   localparam logic [4:0] PH_SCHED    = 5'd14;
   localparam logic [4:0] PH_VALIDITY = 5'd15;
   localparam logic [4:0] PH_SM_LEN   = 5'd20;
   localparam logic [4:0] PH_SM_BYTE  = 5'd21;
   localparam logic [4:0] PH_TAG      = 5'd22;
   localparam logic [4:0] PH_TLEN     = 5'd23;
   localparam logic [4:0] PH_TVAL     = 5'd24;
   localparam logic [4:0] PH_SKIP     = 5'd25;
   localparam logic [4:0] PH_IDLE     = 5'd31;

   localparam logic [4:0] CODE_END    = 5'd27;

   localparam logic [31:0] CMD_SUBMIT_SM = 32'd4;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
   localparam logic [1:0] ST_TRUNCATED   = 2'd2;
   localparam logic [1:0] ST_OVERRUN     = 2'd3;

   // one decoded result beat
   typedef struct packed {
      logic [4:0]  field_code;
      logic [31:0] field_value;
      logic [3:0]  tlv_number;
      logic        pdu_done;
      logic [1:0]  pdu_status;
   } result_type;

   // maximum c-string length for a phase, zero if not a string
   function automatic logic [4:0] string_max(input logic [4:0] ph);
      logic [4:0] mx;
      mx = 5'd0;
      case (ph)
         PH_SVC_TYPE:              mx = 5'd6;
         PH_SRC_ADDR, PH_DST_ADDR: mx = 5'd21;
         PH_SCHED, PH_VALIDITY:    mx = 5'd17;
         default:                  mx = 5'd0;
      endcase
      return mx;
   endfunction

endpackage

### rtl/core/smpp_decode.sv
// ----------------------------------------------------------------------------
// smpp_decode
// parse state registers and next-state logic, one byte per cycle while step is high
// ----------------------------------------------------------------------------
module smpp_decode #(
   parameter int unsigned MAX_TLV_COUNT = smpp_pkg::MaxTlvCount,
   parameter int unsigned LENGTH_BITS   = smpp_pkg::LengthBits
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   first_byte,
   input  logic [LENGTH_BITS-1:0] pdu_length,
   output logic                   res_valid,
   output smpp_pkg::result_type   res
);

   localparam int unsigned CntBits = $clog2(MAX_TLV_COUNT + 1);

   logic [4:0]             phase_ff, phase_in;
   logic [4:0]             bif_ff, bif_in;
   logic [LENGTH_BITS-1:0] consumed_ff, consumed_in;
   logic [LENGTH_BITS-1:0] limit_ff, limit_in;
   logic [31:0]            acc_ff, acc_in;
   logic [CntBits-1:0]     tlvs_ff, tlvs_in;
   logic [15:0]            remain_ff, remain_in;
   logic [1:0]             status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= smpp_pkg::PH_IDLE;
         bif_ff      <= '0;
         consumed_ff <= '0;
         limit_ff    <= '0;
         acc_ff      <= '0;
         tlvs_ff     <= '0;
         remain_ff   <= '0;
         status_ff   <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         bif_ff      <= bif_in;
         consumed_ff <= consumed_in;
         limit_ff    <= limit_in;
         acc_ff      <= acc_in;
         tlvs_ff     <= tlvs_in;
         remain_ff   <= remain_in;
         status_ff   <= status_in;
      end
   end

   logic [4:0]             ph, cur_bif, mx;
   logic [LENGTH_BITS-1:0] cur_cons, left;
   logic [31:0]            cur_acc, word, tvw;
   logic [CntBits-1:0]     cur_tlvs;
   logic [1:0]             cur_st, st;
   logic                   active, have, tlv_go;
   logic [4:0]             code;
   logic [31:0]            val;
   logic [3:0]             tnum;
   logic [15:0]            rem_dec;
   logic [CntBits-1:0]     tlvs_inc;

   always_comb begin
      // start-of-pdu view of the state
      if (first_byte) begin
         ph = 5'd0; cur_bif = '0; cur_acc = '0; cur_tlvs = '0; cur_st = '0;
         cur_cons = '0; limit_in = pdu_length;
         remain_in = '0;
      end else begin
         ph = phase_ff; cur_bif = bif_ff; cur_acc = acc_ff; cur_tlvs = tlvs_ff;
         cur_st = status_ff; cur_cons = consumed_ff; limit_in = limit_ff;
         remain_in = remain_ff;
      end
      active      = first_byte || (phase_ff != smpp_pkg::PH_IDLE);
      consumed_in = cur_cons + 1'b1;
      left        = (limit_in > consumed_in) ? (limit_in - consumed_in) : '0;
      tlv_go      = (left >= LENGTH_BITS'(5)) && (cur_tlvs < CntBits'(MAX_TLV_COUNT));
      tlvs_inc    = cur_tlvs + 1'b1;
      rem_dec     = remain_in - 16'd1;
      mx          = smpp_pkg::string_max(ph);
      word        = {cur_acc[23:0], data_byte};
      tvw         = {16'd0, cur_acc[7:0], data_byte};

      phase_in = ph; bif_in = cur_bif; acc_in = cur_acc; tlvs_in = cur_tlvs;
      status_in = cur_st;
      have = 1'b0; code = '0; val = '0; tnum = '0; st = '0;

      if (ph <= smpp_pkg::PH_SEQ) begin
         acc_in = word;
         bif_in = cur_bif + 5'd1;
         if (cur_bif == 5'd3) begin
            have = 1'b1; code = ph; val = word;
            bif_in = '0; acc_in = '0;
            if (ph == smpp_pkg::PH_CMD_ID && word != smpp_pkg::CMD_SUBMIT_SM)
               status_in = smpp_pkg::ST_UNSUPPORTED;
            if (ph < smpp_pkg::PH_SEQ)
               phase_in = ph + 5'd1;
            else
               phase_in = (cur_st == smpp_pkg::ST_UNSUPPORTED) ?
                          smpp_pkg::PH_SKIP : smpp_pkg::PH_SVC_TYPE;
         end
      end else if (ph <= smpp_pkg::PH_SM_LEN) begin
         have = 1'b1; code = ph; val = {24'd0, data_byte};
         if (mx != 5'd0) begin
            bif_in = cur_bif + 5'd1;
            if (data_byte == 8'd0 || bif_in >= mx) begin
               bif_in = '0; phase_in = ph + 5'd1;
            end
         end else if (ph == smpp_pkg::PH_SM_LEN) begin
            if (data_byte == 8'd0) begin
               bif_in = '0; acc_in = '0;
               phase_in = tlv_go ? smpp_pkg::PH_TAG : smpp_pkg::PH_SKIP;
            end else begin
               remain_in = {8'd0, data_byte};
               phase_in  = smpp_pkg::PH_SM_BYTE;
            end
         end else begin
            phase_in = ph + 5'd1;
         end
      end else if (ph == smpp_pkg::PH_SM_BYTE || ph == smpp_pkg::PH_TVAL) begin
         have = 1'b1; code = ph; val = {24'd0, data_byte};
         tnum = (ph == smpp_pkg::PH_TVAL) ? 4'(cur_tlvs) : 4'd0;
         remain_in = rem_dec;
         if (rem_dec == 16'd0) begin
            if (ph == smpp_pkg::PH_TVAL) tlvs_in = tlvs_inc;
            bif_in = '0; acc_in = '0;
            phase_in = ((left >= LENGTH_BITS'(5)) &&
                        (tlvs_in < CntBits'(MAX_TLV_COUNT))) ?
                       smpp_pkg::PH_TAG : smpp_pkg::PH_SKIP;
         end
      end else if (ph == smpp_pkg::PH_TAG || ph == smpp_pkg::PH_TLEN) begin
         acc_in = tvw;
         bif_in = cur_bif + 5'd1;
         if (cur_bif == 5'd1) begin
            have = 1'b1; code = ph; val = tvw; tnum = 4'(cur_tlvs);
            bif_in = '0; acc_in = '0;
            if (ph == smpp_pkg::PH_TAG) begin
               phase_in = smpp_pkg::PH_TLEN;
            end else if ({{(32-LENGTH_BITS){1'b0}}, left} < tvw) begin
               status_in = smpp_pkg::ST_OVERRUN;
               phase_in  = smpp_pkg::PH_SKIP;
            end else if (tvw == 32'd0) begin
               tlvs_in  = tlvs_inc;
               phase_in = ((left >= LENGTH_BITS'(5)) &&
                           (tlvs_inc < CntBits'(MAX_TLV_COUNT))) ?
                          smpp_pkg::PH_TAG : smpp_pkg::PH_SKIP;
            end else begin
               remain_in = tvw[15:0];
               phase_in  = smpp_pkg::PH_TVAL;
            end
         end
      end

      res.pdu_done   = 1'b0;
      res.pdu_status = '0;
      if (consumed_in >= limit_in) begin
         st = status_in;
         if (st == smpp_pkg::ST_OK && phase_in != smpp_pkg::PH_SKIP)
            st = smpp_pkg::ST_TRUNCATED;
         if (!have) begin
            have = 1'b1; code = smpp_pkg::CODE_END; val = '0; tnum = '0;
         end
         res.pdu_done   = 1'b1;
         res.pdu_status = st;
         phase_in       = smpp_pkg::PH_IDLE;
      end
      res.field_code  = code;
      res.field_value = val;
      res.tlv_number  = tnum;
      res_valid       = active && have;
      if (!active) begin
         phase_in = phase_ff; consumed_in = consumed_ff; limit_in = limit_ff;
      end
   end

endmodule

### rtl/core/smpp_out_skid.sv
// ----------------------------------------------------------------------------
// smpp_out_skid
// result register with one skid entry, so input never waits on an empty slot
// ----------------------------------------------------------------------------
module smpp_out_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  smpp_pkg::result_type in_res,
   output logic                 in_stall,
   output logic                 out_valid,
   output smpp_pkg::result_type out_res,
   input  logic                 out_stall
);

   logic                 main_v_ff, skid_v_ff;
   smpp_pkg::result_type main_ff, skid_ff;

   assign in_stall  = skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_res   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (!main_v_ff || !out_stall) begin
            // main slot frees: refill from skid first
            if (skid_v_ff) begin
               main_ff   <= skid_ff;
               main_v_ff <= 1'b1;
               skid_v_ff <= 1'b0;
            end else begin
               main_ff   <= in_res;
               main_v_ff <= in_valid;
            end
         end else if (in_valid && !skid_v_ff) begin
            skid_ff   <= in_res;
            skid_v_ff <= 1'b1;
         end
      end
   end

endmodule

### rtl/core/smpp_submit_sm_field_parser_core.sv
// ----------------------------------------------------------------------------
// smpp_submit_sm_field_parser_core
// byte-serial smpp submit_sm decoder: header words, body fields, tlvs
// ----------------------------------------------------------------------------
//  channel  | direction | beat
//  req_     | in        | data_byte, first_byte, pdu_length
//  rsp_     | out       | field_code, field_value, tlv_number, pdu_done, pdu_status
//
// one byte per cycle while req_stall is low; each result is registered in the output stage
// the parse state update is a single pass of compare and select logic
// synchronous active-high reset puts the parser idle, no result pending
// a two-entry output stage (register plus skid) absorbs rsp_stall;
// req_stall rises only once both entries hold results
// ----------------------------------------------------------------------------
module smpp_submit_sm_field_parser_core #(
   parameter int unsigned MAX_TLV_COUNT = smpp_pkg::MaxTlvCount,
   parameter int unsigned LENGTH_BITS   = smpp_pkg::LengthBits
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_first_byte,
   input  logic [LENGTH_BITS-1:0] req_pdu_length,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [4:0]             rsp_field_code,
   output logic [31:0]            rsp_field_value,
   output logic [3:0]             rsp_tlv_number,
   output logic                   rsp_pdu_done,
   output logic [1:0]             rsp_pdu_status
);

   logic                 step;
   logic                 dec_valid;
   smpp_pkg::result_type dec_res, out_res;

   // accepted byte advances the parse state
   assign step = req_valid && !req_stall;

   smpp_decode #(
      .MAX_TLV_COUNT(MAX_TLV_COUNT),
      .LENGTH_BITS  (LENGTH_BITS)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_data_byte),
      .first_byte(req_first_byte),
      .pdu_length(req_pdu_length),
      .res_valid (dec_valid),
      .res       (dec_res)
   );

   // result register plus skid
   smpp_out_skid u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (step && dec_valid),
      .in_res   (dec_res),
      .in_stall (req_stall),
      .out_valid(rsp_valid),
      .out_res  (out_res),
      .out_stall(rsp_stall)
   );

   assign rsp_field_code  = out_res.field_code;
   assign rsp_field_value = out_res.field_value;
   assign rsp_tlv_number  = out_res.tlv_number;
   assign rsp_pdu_done    = out_res.pdu_done;
   assign rsp_pdu_status  = out_res.pdu_status;

   // status is only reported on the closing beat
   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pdu_done |-> rsp_pdu_status == smpp_pkg::ST_OK)
      else $error("status on non-final beat");

   // end code always marks a pdu end
   a_end_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_code == smpp_pkg::CODE_END |-> rsp_pdu_done)
      else $error("end code without pdu_done");

   // tlv index only on tlv codes
   a_tlv_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_code < smpp_pkg::PH_TAG |-> rsp_tlv_number == 4'd0)
      else $error("tlv number on non-tlv field");

endmodule

### test/tb_smpp_submit_sm_field_parser_core.sv
// ----------------------------------------------------------------------------
// tb_smpp_submit_sm_field_parser_core
// drives byte streams of smpp pdus (well-formed submit_sm, other commands,
// truncated, tlv overrun, idle noise) and checks every result beat against a
// built-in byte-serial decoder model, with random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_smpp_submit_sm_field_parser_core;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_first_byte = 1'b0;
   logic [15:0] req_pdu_length = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_field_code;
   logic [31:0] rsp_field_value;
   logic [3:0]  rsp_tlv_number;
   logic        rsp_pdu_done;
   logic [1:0]  rsp_pdu_status;

   smpp_submit_sm_field_parser_core dut (.*);

   always #6 clock = ~clock;

   // decoder model state
   logic [4:0]  mdl_phase = smpp_pkg::PH_IDLE;
   logic [4:0]  mdl_in_field;
   logic [15:0] mdl_consumed, mdl_limit, mdl_item_left;
   logic [31:0] mdl_acc;
   logic [3:0]  mdl_tlvs;
   logic [1:0]  mdl_status;

   smpp_pkg::result_type expected_beats[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          hold_off = 1'b0;
   bit          stall_on = 1'b1;

   function automatic logic [15:0] pdu_bytes_left();
      return (mdl_limit > mdl_consumed) ? mdl_limit - mdl_consumed : 16'd0;
   endfunction

   function automatic logic [4:0] str_limit(input logic [4:0] ph);
      case (ph)
         smpp_pkg::PH_SVC_TYPE:                        return 5'd6;
         smpp_pkg::PH_SRC_ADDR, smpp_pkg::PH_DST_ADDR: return 5'd21;
         smpp_pkg::PH_SCHED, smpp_pkg::PH_VALIDITY:    return 5'd17;
         default:                                      return 5'd0;
      endcase
   endfunction

   task automatic enter_tlv_or_skip();
      mdl_in_field = '0;
      mdl_acc = '0;
      mdl_phase = (pdu_bytes_left() >= 16'd5 && mdl_tlvs < smpp_pkg::MaxTlvCount) ?
                  smpp_pkg::PH_TAG : smpp_pkg::PH_SKIP;
   endtask

   // advance the model by one accepted byte, queue the result if any
   task automatic decode_byte(input logic [7:0] b, input logic first, input logic [15:0] len);
      bit have;
      smpp_pkg::result_type r;
      logic [4:0] ph, mx;
      have = 0;
      r = '0;
      if (first) begin
         mdl_in_field = '0; mdl_consumed = '0; mdl_acc = '0; mdl_tlvs = '0;
         mdl_item_left = '0; mdl_status = smpp_pkg::ST_OK;
         mdl_limit = len;
         mdl_phase = smpp_pkg::PH_CMD_LEN;
      end else if (mdl_phase == smpp_pkg::PH_IDLE) begin
         return;
      end
      mdl_consumed++;
      ph = mdl_phase;
      if (ph <= smpp_pkg::PH_SEQ) begin
         mdl_acc = {mdl_acc[23:0], b};
         mdl_in_field++;
         if (mdl_in_field == 5'd4) begin
            have = 1; r.field_code = ph; r.field_value = mdl_acc;
            if (ph == smpp_pkg::PH_CMD_ID && mdl_acc != smpp_pkg::CMD_SUBMIT_SM)
               mdl_status = smpp_pkg::ST_UNSUPPORTED;
            mdl_in_field = '0; mdl_acc = '0;
            if (ph < smpp_pkg::PH_SEQ) mdl_phase = ph + 5'd1;
            else mdl_phase = (mdl_status == smpp_pkg::ST_UNSUPPORTED) ?
                             smpp_pkg::PH_SKIP : smpp_pkg::PH_SVC_TYPE;
         end
      end else if (ph <= smpp_pkg::PH_SM_LEN) begin
         mx = str_limit(ph);
         have = 1; r.field_code = ph; r.field_value = {24'd0, b};
         if (mx != 5'd0) begin
            mdl_in_field++;
            if (b == 8'd0 || mdl_in_field >= mx) begin
               mdl_in_field = '0;
               mdl_phase = ph + 5'd1;
            end
         end else if (ph == smpp_pkg::PH_SM_LEN) begin
            if (b == 8'd0) enter_tlv_or_skip();
            else begin
               mdl_item_left = {8'd0, b};
               mdl_phase = smpp_pkg::PH_SM_BYTE;
            end
         end else mdl_phase = ph + 5'd1;
      end else if (ph == smpp_pkg::PH_SM_BYTE) begin
         have = 1; r.field_code = ph; r.field_value = {24'd0, b};
         mdl_item_left--;
         if (mdl_item_left == 16'd0) enter_tlv_or_skip();
      end else if (ph == smpp_pkg::PH_TAG || ph == smpp_pkg::PH_TLEN) begin
         mdl_acc = {16'd0, mdl_acc[7:0], b};
         mdl_in_field++;
         if (mdl_in_field == 5'd2) begin
            have = 1; r.field_code = ph; r.field_value = mdl_acc; r.tlv_number = mdl_tlvs;
            mdl_in_field = '0; mdl_acc = '0;
            if (ph == smpp_pkg::PH_TAG) mdl_phase = smpp_pkg::PH_TLEN;
            else if (r.field_value > {16'd0, pdu_bytes_left()}) begin
               mdl_status = smpp_pkg::ST_OVERRUN;
               mdl_phase = smpp_pkg::PH_SKIP;
            end else if (r.field_value == 32'd0) begin
               mdl_tlvs++;
               enter_tlv_or_skip();
            end else begin
               mdl_item_left = r.field_value[15:0];
               mdl_phase = smpp_pkg::PH_TVAL;
            end
         end
      end else if (ph == smpp_pkg::PH_TVAL) begin
         have = 1; r.field_code = ph; r.field_value = {24'd0, b}; r.tlv_number = mdl_tlvs;
         mdl_item_left--;
         if (mdl_item_left == 16'd0) begin
            mdl_tlvs++;
            enter_tlv_or_skip();
         end
      end
      // pdu end: status rides on this beat
      if (mdl_consumed >= mdl_limit) begin
         r.pdu_status = mdl_status;
         if (mdl_status == smpp_pkg::ST_OK && mdl_phase != smpp_pkg::PH_SKIP)
            r.pdu_status = smpp_pkg::ST_TRUNCATED;
         if (!have) begin
            have = 1; r.field_code = smpp_pkg::CODE_END; r.field_value = '0;
            r.tlv_number = '0;
         end
         r.pdu_done = 1'b1;
         mdl_phase = smpp_pkg::PH_IDLE;
      end
      if (have) expected_beats.push_back(r);
   endtask

   // one byte beat; gaps come from the burst pattern
   int burst_left = 0;
   task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] len);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8)) : 0;
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_first_byte <= first;
      req_pdu_length <= len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b, first, len);
      @(negedge clock);
   endtask

   // pdu under construction
   logic [7:0] pdu[$];

   task automatic put_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) pdu.push_back(w[8*i +: 8]);
   endtask

   task automatic put_cstr(input int maxlen, input bit full);
      int n;
      n = full ? maxlen : $urandom_range(0, maxlen - 1);
      for (int i = 0; i < n; i++) pdu.push_back(8'($urandom_range(1, 255)));
      if (!full) pdu.push_back(8'd0);
   endtask

   // build a submit_sm with random fields and the given message length and tlv count
   task automatic build_submit(input int sm_len, input int n_tlv, input bit full_str);
      pdu.delete();
      put_word(32'd0);
      put_word(smpp_pkg::CMD_SUBMIT_SM);
      put_word($urandom);
      put_word($urandom);
      put_cstr(6, full_str);
      pdu.push_back(8'($urandom)); pdu.push_back(8'($urandom));
      put_cstr(21, full_str);
      pdu.push_back(8'($urandom)); pdu.push_back(8'($urandom));
      put_cstr(21, full_str);
      repeat (3) pdu.push_back(8'($urandom));
      put_cstr(17, full_str);
      put_cstr(17, full_str);
      repeat (4) pdu.push_back(8'($urandom));
      pdu.push_back(8'(sm_len));
      for (int i = 0; i < sm_len; i++) pdu.push_back(8'($urandom));
      for (int t = 0; t < n_tlv; t++) begin
         int vl;
         vl = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         pdu.push_back(8'($urandom)); pdu.push_back(8'($urandom));
         pdu.push_back(8'(vl >> 8)); pdu.push_back(8'(vl));
         for (int i = 0; i < vl; i++) pdu.push_back(8'($urandom));
      end
   endtask

   task automatic send_pdu(input logic [15:0] len);
      foreach (pdu[i]) send_byte(pdu[i], i == 0, i == 0 ? len : 16'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // ---------------- tests ----------------
   task automatic test_header_only();
      pdu.delete();
      put_word(32'hFFFF_FFFF); put_word(32'h8000_0004); put_word(32'd0);
      put_word(32'h0102_0304);
      pdu.push_back(8'hFF); pdu.push_back(8'h00);
      send_pdu(16'd18);               // unsupported command, trailing bytes skipped
      pdu.delete(); pdu.push_back(8'hAA);
      send_pdu(16'd0);                // zero length ends on first byte
      send_pdu(16'd1);
      send_byte(8'h55, 1'b0, 16'hFFFF);  // idle noise
      pdu.delete(); put_word(32'd0); put_word(smpp_pkg::CMD_SUBMIT_SM);
      send_pdu(16'hFFFF);             // restart mid-pdu abandons this one
      pdu.delete(); put_word(32'd0); pdu.push_back(8'h00);
      send_pdu(16'd5);                // truncated in header
      wait_drained();
   endtask

   task automatic test_submit_directed();
      build_submit(0, 0, 1);
      send_pdu(16'(pdu.size()));      // full-length strings, no tlvs
      build_submit(3, 1, 0);
      send_pdu(16'(pdu.size() + 4));  // truncated inside a trailing region
      build_submit(2, 11, 0);
      send_pdu(16'(pdu.size()));      // more tlvs than the limit
      build_submit(1, 0, 0);
      pdu.push_back(8'h12); pdu.push_back(8'h34); pdu.push_back(8'hFF); pdu.push_back(8'hFF);
      pdu.push_back(8'h00);
      send_pdu(16'(pdu.size()));      // tlv length overrun
      build_submit(255, 0, 0);
      send_pdu(16'(pdu.size()));      // longest short message
      wait_drained();
   endtask

   task automatic test_random_pdus();
      int sent;
      sent = 0;
      while (sent < 1200) begin
         int kind;
         int len;
         kind = $urandom_range(0, 9);
         build_submit($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 8),
                      $urandom_range(0, 4) == 0 ? $urandom_range(0, 12) : $urandom_range(0, 3),
                      $urandom_range(0, 7) == 0);
         len = pdu.size();
         if (kind == 0) pdu[7] = 8'($urandom);             // other command
         if (kind == 1) len = $urandom_range(0, len);      // short length
         if (kind == 2) len = len + $urandom_range(0, 6);  // truncated stream
         if (kind == 3) begin
            pdu.delete();
            repeat ($urandom_range(1, 24)) pdu.push_back(8'($urandom));
            len = $urandom_range(0, 65535);
         end
         if (kind == 4) send_byte(8'($urandom), 1'b0, 16'($urandom));
         send_pdu(16'(len));
         sent += pdu.size();
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      build_submit(20, 2, 0);
      send_pdu(16'(pdu.size()));
      wait_drained();
   endtask

   // ---------------- receiver ----------------
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if (!stall_on) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // long hold-off counted in cycles, then random stall pattern resumes
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
      end
   end

   // periods without stalls
   initial begin
      forever begin
         repeat (300) @(posedge clock);
         stall_on = ~stall_on;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         smpp_pkg::result_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat code %0d value %0h", $time,
                     rsp_field_code, rsp_field_value);
            error_count++;
         end else begin
            want = expected_beats.pop_front();
            if (want.field_code !== rsp_field_code) begin
               $display("%0t: field_code exp %0d got %0d", $time, want.field_code, rsp_field_code);
               error_count++;
            end
            if (want.field_value !== rsp_field_value) begin
               $display("%0t: field_value exp %0h got %0h", $time,
                        want.field_value, rsp_field_value);
               error_count++;
            end
            if (want.tlv_number !== rsp_tlv_number) begin
               $display("%0t: tlv_number exp %0d got %0d", $time, want.tlv_number, rsp_tlv_number);
               error_count++;
            end
            if (want.pdu_done !== rsp_pdu_done) begin
               $display("%0t: pdu_done exp %0d got %0d", $time, want.pdu_done, rsp_pdu_done);
               error_count++;
            end
            if (want.pdu_status !== rsp_pdu_status) begin
               $display("%0t: pdu_status exp %0d got %0d", $time, want.pdu_status, rsp_pdu_status);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("** smpp_submit_sm_field_parser_core: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_header_only();
      test_submit_directed();
      test_backpressure();
      test_random_pdus();
      repeat (10) @(negedge clock);
      if (error_count == 0 && expected_beats.size() == 0)
         $display("** smpp_submit_sm_field_parser_core: PASSED **");
      else
         $display("** smpp_submit_sm_field_parser_core: FAILED **");
      $finish;
   end

endmodule
